// ----- rtl/core/olt_pkg.sv -----
`timescale 1ns / 1ps

package olt_pkg;

	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SEARCH     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DELETE     = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INSERT,
		S_WALK,
		S_RESULT
	} state_t;

	// write enables of the link memories plus the shared read enable
	typedef struct packed {
		logic rd;
		logic val;
		logic nxt;
		logic prv;
	} link_we_t;

endpackage

// ----- rtl/core/ordered_list_table_unit.sv -----
`timescale 1ns / 1ps
// Sequence: an insert passes through S_INSERT and S_RESULT, a full insert goes straight to S_RESULT;
// search and delete walk k slots in S_WALK (none on an empty list, else 1..count) before S_RESULT.
// Throughput: one request at a time; the chain walk is bound by the link memory read port,
// one slot per cycle.
// Reset: arst_n empties the list at once; slot memories need no clearing.

module ordered_list_table_unit import olt_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32,
	localparam int IW        = $clog2(CAPACITY),
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [KIND_W-1:0]     kind,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [CNT_W-1:0]      position,
	output logic [CNT_W-1:0]      count
);

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	state_t state_q, state_d;

	logic [IW-1:0]         head_q, head_d;
	logic [IW-1:0]         tail_q, tail_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [IW-1:0]         cur_q, cur_d;
	logic [CNT_W-1:0]      step_q, step_d;
	logic [STATUS_W-1:0]   res_status_q, res_status_d;
	logic [CNT_W-1:0]      res_pos_q, res_pos_d;
	logic [KIND_W-1:0]     kind_q;
	logic [DATA_WIDTH-1:0] val_q;

	logic                  out_valid_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic [CNT_W-1:0]      out_pos_q;
	logic [CNT_W-1:0]      out_count_q;

	logic                  accept;
	logic                  load;

	link_we_t              we;
	logic [IW-1:0]         rd_addr;
	logic [DATA_WIDTH-1:0] rd_val;
	logic [IW-1:0]         rd_nxt;
	logic [IW-1:0]         rd_prv;
	logic [IW-1:0]         val_waddr;
	logic [DATA_WIDTH-1:0] val_wdata;
	logic [IW-1:0]         nxt_waddr;
	logic [IW-1:0]         nxt_wdata;
	logic [IW-1:0]         prv_waddr;
	logic [IW-1:0]         prv_wdata;

	logic                  alloc_req;
	logic [IW-1:0]         alloc_slot;
	logic                  free_req;

	olt_link_mem #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_link_mem (
		.clk       (clk),
		.we        (we),
		.rd_addr   (rd_addr),
		.rd_val    (rd_val),
		.rd_nxt    (rd_nxt),
		.rd_prv    (rd_prv),
		.val_waddr (val_waddr),
		.val_wdata (val_wdata),
		.nxt_waddr (nxt_waddr),
		.nxt_wdata (nxt_wdata),
		.prv_waddr (prv_waddr),
		.prv_wdata (prv_wdata)
	);

	olt_free_pool #(
		.CAPACITY (CAPACITY)
	) u_free_pool (
		.clk        (clk),
		.arst_n     (arst_n),
		.alloc_req  (alloc_req),
		.alloc_slot (alloc_slot),
		.free_req   (free_req),
		.free_slot  (cur_q)
	);

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		tail_d       = tail_q;
		count_d      = count_q;
		cur_d        = cur_q;
		step_d       = step_q;
		res_status_d = res_status_q;
		res_pos_d    = res_pos_q;
		we           = '0;
		rd_addr      = head_q;
		val_waddr    = alloc_slot;
		val_wdata    = val_q;
		nxt_waddr    = '0;
		nxt_wdata    = '0;
		prv_waddr    = '0;
		prv_wdata    = '0;
		alloc_req    = 1'b0;
		free_req     = 1'b0;
		load         = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_status_d = ST_OK;
					res_pos_d    = '0;
					case (kind)
						KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
							if (count_q == CAP_CNT) begin
								res_status_d = ST_FULL;
								state_d      = S_RESULT;
							end else begin
								alloc_req = 1'b1;
								state_d   = S_INSERT;
							end
						end
						default: begin
							if (count_q == '0) begin
								res_status_d = ST_MISS;
								state_d      = S_RESULT;
							end else begin
								we.rd   = 1'b1;
								rd_addr = head_q;
								cur_d   = head_q;
								step_d  = CNT_W'(1);
								state_d = S_WALK;
							end
						end
					endcase
				end
			end

			S_INSERT: begin
				we.val = 1'b1;
				if (count_q == '0) begin
					head_d = alloc_slot;
					tail_d = alloc_slot;
				end else if (kind_q == KIND_PUSH_FRONT) begin
					we.nxt    = 1'b1;
					nxt_waddr = alloc_slot;
					nxt_wdata = head_q;
					we.prv    = 1'b1;
					prv_waddr = head_q;
					prv_wdata = alloc_slot;
					head_d    = alloc_slot;
				end else begin
					we.prv    = 1'b1;
					prv_waddr = alloc_slot;
					prv_wdata = tail_q;
					we.nxt    = 1'b1;
					nxt_waddr = tail_q;
					nxt_wdata = alloc_slot;
					tail_d    = alloc_slot;
				end
				count_d = count_q + CNT_W'(1);
				state_d = S_RESULT;
			end

			S_WALK: begin
				if (rd_val == val_q) begin
					state_d = S_RESULT;
					if (kind_q == KIND_SEARCH) begin
						res_pos_d = step_q;
					end else begin
						// unlink the matching slot and hand it back to the pool
						if (cur_q == head_q && cur_q == tail_q) begin
							head_d = head_q;
						end else if (cur_q == head_q) begin
							head_d = rd_nxt;
						end else if (cur_q == tail_q) begin
							tail_d = rd_prv;
						end else begin
							we.nxt    = 1'b1;
							nxt_waddr = rd_prv;
							nxt_wdata = rd_nxt;
							we.prv    = 1'b1;
							prv_waddr = rd_nxt;
							prv_wdata = rd_prv;
						end
						free_req = 1'b1;
						count_d  = count_q - CNT_W'(1);
					end
				end else if (step_q == count_q) begin
					res_status_d = ST_MISS;
					state_d      = S_RESULT;
				end else begin
					we.rd   = 1'b1;
					rd_addr = rd_nxt;
					cur_d   = rd_nxt;
					step_d  = step_q + CNT_W'(1);
				end
			end

			S_RESULT: begin
				if (!out_valid_q || !out_stall) begin
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		step_q       <= step_d;
		res_status_q <= res_status_d;
		res_pos_q    <= res_pos_d;
		if (accept) begin
			kind_q <= kind;
			val_q  <= value;
		end
		if (load) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
			out_count_q  <= count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign position  = out_pos_q;
	assign count     = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("element count above capacity");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_WALK |-> (step_q != '0 && step_q <= count_q))
		else $error("chain walk beyond element count");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == ST_FULL |-> out_count_q == CAP_CNT)
		else $error("full status with list not full");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INSERT |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow the list");

endmodule

// ----- rtl/core/olt_link_mem.sv -----
`timescale 1ns / 1ps

module olt_link_mem import olt_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32,
	localparam int IW        = $clog2(CAPACITY)
) (
	input  logic                  clk,
	input  link_we_t              we,
	input  logic [IW-1:0]         rd_addr,
	output logic [DATA_WIDTH-1:0] rd_val,
	output logic [IW-1:0]         rd_nxt,
	output logic [IW-1:0]         rd_prv,
	input  logic [IW-1:0]         val_waddr,
	input  logic [DATA_WIDTH-1:0] val_wdata,
	input  logic [IW-1:0]         nxt_waddr,
	input  logic [IW-1:0]         nxt_wdata,
	input  logic [IW-1:0]         prv_waddr,
	input  logic [IW-1:0]         prv_wdata
);

	logic [DATA_WIDTH-1:0] val_mem [CAPACITY];
	logic [IW-1:0]         nxt_mem [CAPACITY];
	logic [IW-1:0]         prv_mem [CAPACITY];

	logic [DATA_WIDTH-1:0] rd_val_q;
	logic [IW-1:0]         rd_nxt_q;
	logic [IW-1:0]         rd_prv_q;

	always_ff @(posedge clk) begin
		if (we.val) begin
			val_mem[val_waddr] <= val_wdata;
		end
		if (we.nxt) begin
			nxt_mem[nxt_waddr] <= nxt_wdata;
		end
		if (we.prv) begin
			prv_mem[prv_waddr] <= prv_wdata;
		end
		if (we.rd) begin
			rd_val_q <= val_mem[rd_addr];
			rd_nxt_q <= nxt_mem[rd_addr];
			rd_prv_q <= prv_mem[rd_addr];
		end
	end

	assign rd_val = rd_val_q;
	assign rd_nxt = rd_nxt_q;
	assign rd_prv = rd_prv_q;

endmodule

// ----- rtl/core/olt_free_pool.sv -----
`timescale 1ns / 1ps

module olt_free_pool import olt_pkg::*; #(
	parameter int CAPACITY = 64,
	localparam int IW      = $clog2(CAPACITY),
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          alloc_req,
	output logic [IW-1:0] alloc_slot,
	input  logic          free_req,
	input  logic [IW-1:0] free_slot
);

	// freed slots go on a stack; slots never handed out come from a fill count
	logic [IW-1:0]    stk [CAPACITY];
	logic [CNT_W-1:0] sp_q;
	logic [CNT_W-1:0] fresh_q;
	logic             use_stk_q;
	logic [IW-1:0]    stk_rd_q;
	logic [IW-1:0]    fresh_rd_q;
	logic [IW-1:0]    pop_idx;

	assign pop_idx = IW'(sp_q - CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q      <= '0;
			fresh_q   <= '0;
			use_stk_q <= 1'b0;
		end else if (free_req) begin
			sp_q <= sp_q + CNT_W'(1);
		end else if (alloc_req) begin
			use_stk_q <= (sp_q != '0);
			if (sp_q != '0) begin
				sp_q <= sp_q - CNT_W'(1);
			end else begin
				fresh_q <= fresh_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_req) begin
			stk[sp_q[IW-1:0]] <= free_slot;
		end
		if (alloc_req) begin
			stk_rd_q   <= stk[pop_idx];
			fresh_rd_q <= fresh_q[IW-1:0];
		end
	end

	assign alloc_slot = use_stk_q ? stk_rd_q : fresh_rd_q;

endmodule

// ----- tb/ordered_list_table_checker.sv -----
`timescale 1ns / 1ps

module ordered_list_table_checker import olt_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  logic [KIND_W-1:0]     kind,
	input  logic [DATA_WIDTH-1:0] value,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  logic [STATUS_W-1:0]   status,
	input  logic [CNT_W-1:0]      position,
	input  logic [CNT_W-1:0]      count,
	output int                    errors,
	output int                    pending,
	output int                    checked,
	output int                    full_refusals,
	output int                    search_hits,
	output int                    deletions
);

	typedef struct {
		logic [KIND_W-1:0]   kind;
		logic [STATUS_W-1:0] status;
		logic [CNT_W-1:0]    position;
		logic [CNT_W-1:0]    count;
	} answer_t;

	// list contents in order, head first
	logic [DATA_WIDTH-1:0] list_model[$];
	answer_t               answers[$];

	function automatic answer_t apply_request(input logic [KIND_W-1:0] k,
						  input logic [DATA_WIDTH-1:0] v);
		answer_t a;
		int      hit;
		a.kind     = k;
		a.status   = ST_OK;
		a.position = '0;
		hit        = -1;
		for (int i = 0; i < list_model.size(); i++)
			if (hit < 0 && list_model[i] == v)
				hit = i;
		case (k)
			KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
				if (list_model.size() >= CAPACITY)
					a.status = ST_FULL;
				else if (k == KIND_PUSH_FRONT)
					list_model.push_front(v);
				else
					list_model.push_back(v);
			end
			KIND_SEARCH: begin
				if (hit < 0)
					a.status = ST_MISS;
				else
					a.position = CNT_W'(hit + 1);
			end
			KIND_DELETE: begin
				if (hit < 0)
					a.status = ST_MISS;
				else
					list_model.delete(hit);
			end
		endcase
		a.count = CNT_W'(list_model.size());
		return a;
	endfunction

	task automatic report(input string msg);
		errors++;
		$display("%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (in_valid && !in_stall)
				answers.push_back(apply_request(kind, value));
			if (out_valid && !out_stall) begin
				if (answers.size() == 0) begin
					report($sformatf("result with no request waiting: status %0d position %0d count %0d",
						status, position, count));
				end else begin
					want = answers.pop_front();
					checked++;
					if (status !== want.status)
						report($sformatf("status: got %0d, expected %0d (kind %0d)",
							status, want.status, want.kind));
					if (position !== want.position)
						report($sformatf("position: got %0d, expected %0d (kind %0d)",
							position, want.position, want.kind));
					if (count !== want.count)
						report($sformatf("count: got %0d, expected %0d (kind %0d)",
							count, want.count, want.kind));
					if (want.status == ST_FULL)
						full_refusals++;
					if (want.kind == KIND_SEARCH && want.status == ST_OK)
						search_hits++;
					if (want.kind == KIND_DELETE && want.status == ST_OK)
						deletions++;
				end
			end
			pending <= answers.size();
		end
	end

endmodule

// ----- tb/ordered_list_table_unit_test.sv -----
`timescale 1ns / 1ps

module ordered_list_table_unit_test;
	import olt_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int DATA_WIDTH   = 32;
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int RANDOM_ITEMS = 680;
	localparam int PHASE_LEN    = 110;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [KIND_W-1:0]     kind;
	logic [DATA_WIDTH-1:0] value;
	logic                  out_valid;
	logic                  out_stall;
	logic [STATUS_W-1:0]   status;
	logic [CNT_W-1:0]      position;
	logic [CNT_W-1:0]      count;

	bit                    quiet;
	int                    errors, pending, checked, full_refusals, search_hits, deletions;
	logic [DATA_WIDTH-1:0] pool[16];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ordered_list_table_unit #(
		.CAPACITY(CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.position(position),
		.count(count)
	);

	ordered_list_table_checker #(
		.CAPACITY(CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) list_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.position(position),
		.count(count),
		.errors(errors),
		.pending(pending),
		.checked(checked),
		.full_refusals(full_refusals),
		.search_hits(search_hits),
		.deletions(deletions)
	);

	task automatic send(input logic [KIND_W-1:0] k, input logic [DATA_WIDTH-1:0] v);
		while (!quiet && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		kind     <= k;
		value    <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// mostly values from a small pool so that duplicates and hits are common
	function automatic logic [DATA_WIDTH-1:0] pick_value();
		if ($urandom_range(9) == 0)
			return DATA_WIDTH'($urandom);
		return pool[$urandom_range(15)];
	endfunction

	initial begin
		int                r;
		int                insert_pct;
		int                search_pct;
		int                wait_cycles;
		logic [KIND_W-1:0] k;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		kind     <= KIND_SEARCH;
		value    <= '0;
		quiet    <= 1'b0;
		pool[0]  = '0;
		pool[1]  = '1;
		for (int i = 2; i < 16; i++)
			pool[i] = DATA_WIDTH'($urandom);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list, duplicates, head/middle/tail removal, reuse after emptying
		send(KIND_SEARCH, '0);
		send(KIND_DELETE, 32'h0000_0005);
		send(KIND_PUSH_BACK, '0);
		send(KIND_PUSH_FRONT, '1);
		send(KIND_PUSH_BACK, 32'hA5A5_A5A5);
		send(KIND_PUSH_BACK, '0);
		send(KIND_SEARCH, '0);
		send(KIND_SEARCH, '1);
		send(KIND_SEARCH, 32'hA5A5_A5A5);
		send(KIND_SEARCH, 32'h5A5A_5A5A);
		send(KIND_DELETE, 32'hA5A5_A5A5);
		send(KIND_DELETE, '1);
		send(KIND_DELETE, '0);
		send(KIND_PUSH_FRONT, 32'h0000_0001);
		send(KIND_DELETE, '0);
		send(KIND_DELETE, 32'h0000_0001);
		send(KIND_SEARCH, 32'h0000_0001);
		send(KIND_PUSH_FRONT, 32'h0000_0007);
		send(KIND_SEARCH, 32'h0000_0007);
		send(KIND_DELETE, 32'h1234_5678);
		send(KIND_DELETE, 32'h0000_0007);

		// alternate growing phases, which run into the full list, with draining ones
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			quiet <= (i >= 300 && i < 420);
			if ((i / PHASE_LEN) % 2 == 0) begin
				insert_pct = 82;
				search_pct = 12;
			end else begin
				insert_pct = 10;
				search_pct = 25;
			end
			r = $urandom_range(99);
			if (r < insert_pct)
				k = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
			else if (r < insert_pct + search_pct)
				k = KIND_SEARCH;
			else
				k = KIND_DELETE;
			send(k, pick_value());
		end
		in_valid <= 1'b0;

		wait_cycles = 0;
		do begin
			@(posedge clk);
			wait_cycles++;
		end while (pending != 0 && wait_cycles < 5000);
		repeat (80) @(posedge clk);

		$display("summary: %0d results checked, %0d refused on a full list,", checked,
			full_refusals);
		$display("summary: %0d search hits, %0d deletions, %0d requests unanswered",
			search_hits, deletions, pending);
		if (errors == 0 && pending == 0)
			$display("ordered_list_table_unit_test passed");
		else
			$display("ordered_list_table_unit_test failed");
		$finish;
	end

	// receiver: random stalls, one long hold-off so the block backs up
	initial begin
		int cyc;
		out_stall <= 1'b0;
		cyc = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 1500) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end
			out_stall <= !quiet && ($urandom_range(99) < 21);
		end
	end

	initial begin
		#5_000_000;
		$display("ordered_list_table_unit_test failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/olt_pkg.sv
rtl/core/olt_link_mem.sv
rtl/core/olt_free_pool.sv
rtl/core/ordered_list_table_unit.sv
tb/ordered_list_table_checker.sv
tb/ordered_list_table_unit_test.sv
